>>> src/satoi_pkg.sv
// Package: shared constants and types of the swept box time-of-impact block
`default_nettype none
package satoi_pkg;

    // Field widths
    localparam int EDGE_W     = 24;
    localparam int VEL_W      = 16;
    localparam int SPAN_W     = 16;
    localparam int FRAC_OUT_W = 17;

    // Internal widths
    localparam int D_W        = 32;                  // displacement, signed
    localparam int GAP_W      = EDGE_W + 1;          // edge gap, signed
    localparam int FRAC_SH    = 16;                  // Q.16 scaling
    localparam int MAG_W      = GAP_W + FRAC_SH;     // |gap| << 16
    localparam int DM_W       = D_W - 1;             // |displacement|
    localparam int Q_W        = 24;                  // saturated fraction, signed
    localparam int THR_W      = DM_W + Q_W - 1;      // |d| << 23
    localparam int DIV_STAGES = 8;
    localparam int DIV_BITS   = Q_W / DIV_STAGES;
    localparam int DLO_W      = 16;                  // low half of d for split multiply
    localparam int PLO_W      = Q_W + DLO_W + 1;
    localparam int PHI_W      = Q_W + D_W - DLO_W;
    localparam int SH_W       = 58;
    localparam int NFACE      = 4;
    localparam int GEOM_DLY   = DIV_STAGES + 1;
    localparam int NSTG       = 2 + GEOM_DLY + 4;    // prep, divider, overlap, output

    // Face order
    localparam int FACE_R = 0;
    localparam int FACE_L = 1;
    localparam int FACE_T = 2;
    localparam int FACE_B = 3;

    // Fraction constants, Q.16
    localparam logic signed [Q_W-1:0] Q_SAT_MAX = 24'sh7FFFFF;
    localparam logic signed [Q_W-1:0] Q_SAT_MIN = 24'sh800000;
    localparam logic signed [Q_W-1:0] Q_START   = 24'sd6488064;
    localparam logic signed [Q_W-1:0] Q_ONE     = 24'sd65536;
    localparam logic signed [Q_W-1:0] Q_ZERO    = 24'sd0;

    typedef enum logic [1:0] {
        HIT_NONE  = 2'd0,
        HIT_TOUCH = 2'd1,
        HIT_SPAN  = 2'd2
    } t_hit_status;

    typedef struct packed {
        logic signed [EDGE_W-1:0] a_left;
        logic signed [EDGE_W-1:0] a_right;
        logic signed [EDGE_W-1:0] a_down;
        logic signed [EDGE_W-1:0] a_up;
        logic signed [EDGE_W-1:0] b_left;
        logic signed [EDGE_W-1:0] b_right;
        logic signed [EDGE_W-1:0] b_down;
        logic signed [EDGE_W-1:0] b_up;
        logic signed [VEL_W-1:0]  rel_vel_x;
        logic signed [VEL_W-1:0]  rel_vel_y;
        logic [SPAN_W-1:0]        time_span;
    } t_in_item;

    typedef struct packed {
        t_hit_status             hit_status;
        logic [FRAC_OUT_W-1:0]   impact_fraction;
        logic                    normal_up;
        logic                    normal_down;
        logic                    normal_left;
        logic                    normal_right;
    } t_out_item;

    // Gaps and displacements carried alongside the divider
    typedef struct packed {
        logic signed [GAP_W-1:0] gap_r;
        logic signed [GAP_W-1:0] gap_l;
        logic signed [GAP_W-1:0] gap_t;
        logic signed [GAP_W-1:0] gap_b;
        logic signed [D_W-1:0]   d_x;
        logic signed [D_W-1:0]   d_y;
        logic                    ok_x;
        logic                    ok_y;
    } t_geom;

    // Divider setup for one face
    typedef struct packed {
        logic [DM_W-1:0] rem;
        logic [Q_W-1:0]  low;
        logic [DM_W-1:0] dm;
        logic            neg;
        logic            sat;
    } t_div_in;

endpackage
`default_nettype wire

>>> src/satoi_stream_if.sv
// Interface: valid/ready channel with a typed payload
`default_nettype none
interface satoi_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> src/satoi_prep.sv
// Module: displacement multiply, edge gaps and divider setup (two stages)
`default_nettype none
module satoi_prep (
    input  wire logic                i_clk,
    input  wire logic [1:0]          i_en,
    input  wire satoi_pkg::t_in_item i_item,
    output satoi_pkg::t_geom         o_geom,
    output satoi_pkg::t_div_in       o_div [satoi_pkg::NFACE]
);
    localparam int EXT_V = satoi_pkg::D_W - satoi_pkg::VEL_W;
    localparam int EXT_S = satoi_pkg::D_W - satoi_pkg::SPAN_W;

    satoi_pkg::t_in_item                r_item;
    logic signed [satoi_pkg::D_W-1:0]   r_dx, r_dy, n_dx, n_dy;
    logic signed [satoi_pkg::GAP_W-1:0] n_gap [satoi_pkg::NFACE];
    satoi_pkg::t_geom                   n_geom, r_geom;
    satoi_pkg::t_div_in                 n_div [satoi_pkg::NFACE];
    satoi_pkg::t_div_in                 r_div [satoi_pkg::NFACE];

    // Stage 1: displacement = velocity * span
    always_comb begin
        n_dx = $signed({{EXT_V{i_item.rel_vel_x[satoi_pkg::VEL_W-1]}}, i_item.rel_vel_x})
             * $signed({{EXT_S{1'b0}}, i_item.time_span});
        n_dy = $signed({{EXT_V{i_item.rel_vel_y[satoi_pkg::VEL_W-1]}}, i_item.rel_vel_y})
             * $signed({{EXT_S{1'b0}}, i_item.time_span});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_item <= i_item;
            r_dx   <= n_dx;
            r_dy   <= n_dy;
        end
    end

    // Stage 2: gaps, magnitudes, saturation check
    always_comb begin
        logic signed [satoi_pkg::D_W-1:0] d;
        logic signed [satoi_pkg::D_W-1:0] dabs;
        logic [satoi_pkg::GAP_W-1:0]      gabs;
        logic [satoi_pkg::MAG_W-1:0]      mag;
        logic [satoi_pkg::DM_W-1:0]       dm;
        logic [satoi_pkg::THR_W-1:0]      thr;
        logic                             neg;

        n_gap[satoi_pkg::FACE_R] = satoi_pkg::GAP_W'($signed(r_item.b_right))
                                 - satoi_pkg::GAP_W'($signed(r_item.a_left));
        n_gap[satoi_pkg::FACE_L] = satoi_pkg::GAP_W'($signed(r_item.b_left))
                                 - satoi_pkg::GAP_W'($signed(r_item.a_right));
        n_gap[satoi_pkg::FACE_T] = satoi_pkg::GAP_W'($signed(r_item.b_up))
                                 - satoi_pkg::GAP_W'($signed(r_item.a_down));
        n_gap[satoi_pkg::FACE_B] = satoi_pkg::GAP_W'($signed(r_item.b_down))
                                 - satoi_pkg::GAP_W'($signed(r_item.a_up));

        n_geom.gap_r = n_gap[satoi_pkg::FACE_R];
        n_geom.gap_l = n_gap[satoi_pkg::FACE_L];
        n_geom.gap_t = n_gap[satoi_pkg::FACE_T];
        n_geom.gap_b = n_gap[satoi_pkg::FACE_B];
        n_geom.d_x   = r_dx;
        n_geom.d_y   = r_dy;
        n_geom.ok_x  = (r_dx != '0);
        n_geom.ok_y  = (r_dy != '0);

        for (int k = 0; k < satoi_pkg::NFACE; k++) begin
            d    = (k < 2) ? r_dx : r_dy;
            dabs = d[satoi_pkg::D_W-1] ? -d : d;
            dm   = dabs[satoi_pkg::DM_W-1:0];
            gabs = n_gap[k][satoi_pkg::GAP_W-1] ? satoi_pkg::GAP_W'(-n_gap[k])
                                                : satoi_pkg::GAP_W'(n_gap[k]);
            mag  = {gabs, {satoi_pkg::FRAC_SH{1'b0}}};
            neg  = n_gap[k][satoi_pkg::GAP_W-1] ^ d[satoi_pkg::D_W-1];
            thr  = {dm, {(satoi_pkg::Q_W-1){1'b0}}};
            // floor toward minus infinity: negative side saturates only past 2^23
            n_div[k].sat = neg ? (satoi_pkg::THR_W'(mag) > thr)
                               : (satoi_pkg::THR_W'(mag) >= thr);
            n_div[k].neg = neg;
            n_div[k].dm  = dm;
            n_div[k].rem = satoi_pkg::DM_W'(mag[satoi_pkg::MAG_W-1:satoi_pkg::Q_W]);
            n_div[k].low = mag[satoi_pkg::Q_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_geom <= n_geom;
            r_div  <= n_div;
        end
    end

    assign o_geom = r_geom;
    assign o_div  = r_div;
endmodule
`default_nettype wire

>>> src/satoi_div.sv
// Module: pipelined restoring divider, one face, with floor and saturation fixup
`default_nettype none
module satoi_div (
    input  wire logic                              i_clk,
    input  wire logic [satoi_pkg::DIV_STAGES:0]    i_en,
    input  wire satoi_pkg::t_div_in                i_div,
    output logic signed [satoi_pkg::Q_W-1:0]       o_q
);
    localparam int NS = satoi_pkg::DIV_STAGES;

    logic [satoi_pkg::DM_W-1:0] r_rem [NS];
    logic [satoi_pkg::Q_W-1:0]  r_low [NS];
    logic [satoi_pkg::Q_W-1:0]  r_quo [NS];
    logic [satoi_pkg::DM_W-1:0] r_dm  [NS];
    logic                       r_neg [NS];
    logic                       r_sat [NS];
    logic signed [satoi_pkg::Q_W-1:0] r_q, n_q;

    // Iteration stages, DIV_BITS quotient bits each
    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [satoi_pkg::DM_W-1:0] w_rem, n_rem;
        logic [satoi_pkg::Q_W-1:0]  w_low, w_quo, n_low, n_quo;
        logic [satoi_pkg::DM_W-1:0] w_dm;
        logic                       w_neg, w_sat;

        if (s == 0) begin : g_src0
            assign w_rem = i_div.rem;
            assign w_low = i_div.low;
            assign w_quo = '0;
            assign w_dm  = i_div.dm;
            assign w_neg = i_div.neg;
            assign w_sat = i_div.sat;
        end else begin : g_srcn
            assign w_rem = r_rem[s-1];
            assign w_low = r_low[s-1];
            assign w_quo = r_quo[s-1];
            assign w_dm  = r_dm[s-1];
            assign w_neg = r_neg[s-1];
            assign w_sat = r_sat[s-1];
        end

        always_comb begin
            logic [satoi_pkg::DM_W:0] r2;
            n_rem = w_rem;
            n_low = w_low;
            n_quo = w_quo;
            for (int i = 0; i < satoi_pkg::DIV_BITS; i++) begin
                r2    = {n_rem, n_low[satoi_pkg::Q_W-1]};
                n_low = n_low << 1;
                if (r2 >= {1'b0, w_dm}) begin
                    n_rem = satoi_pkg::DM_W'(r2 - {1'b0, w_dm});
                    n_quo = {n_quo[satoi_pkg::Q_W-2:0], 1'b1};
                end else begin
                    n_rem = r2[satoi_pkg::DM_W-1:0];
                    n_quo = {n_quo[satoi_pkg::Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_low[s] <= n_low;
                r_quo[s] <= n_quo;
                r_dm[s]  <= w_dm;
                r_neg[s] <= w_neg;
                r_sat[s] <= w_sat;
            end
        end
    end

    // Fixup: ceiling on the negative side, then sign and saturation
    always_comb begin
        logic [satoi_pkg::Q_W:0] val;
        val = {1'b0, r_quo[NS-1]} + {{satoi_pkg::Q_W{1'b0}}, (r_rem[NS-1] != '0)};
        if (r_sat[NS-1]) begin
            n_q = r_neg[NS-1] ? satoi_pkg::Q_SAT_MIN : satoi_pkg::Q_SAT_MAX;
        end else if (r_neg[NS-1]) begin
            n_q = satoi_pkg::Q_W'(-val);
        end else begin
            n_q = $signed(r_quo[NS-1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[NS]) begin
            r_q <= n_q;
        end
    end

    assign o_q = r_q;
endmodule
`default_nettype wire

>>> src/satoi_ovl.sv
// Module: overlap test at each face fraction (split multiply, sum, compare)
`default_nettype none
module satoi_ovl (
    input  wire logic                         i_clk,
    input  wire logic [2:0]                   i_en,
    input  wire logic signed [satoi_pkg::Q_W-1:0] i_q [satoi_pkg::NFACE],
    input  wire satoi_pkg::t_geom             i_geom,
    output logic signed [satoi_pkg::Q_W-1:0]  o_q [satoi_pkg::NFACE],
    output logic [satoi_pkg::NFACE-1:0]       o_ok,
    output logic [satoi_pkg::NFACE-1:0]       o_cand
);
    localparam int NF  = satoi_pkg::NFACE;
    localparam int QW  = satoi_pkg::Q_W;
    localparam int GW  = satoi_pkg::GAP_W;
    localparam int DHW = satoi_pkg::D_W - satoi_pkg::DLO_W;

    logic signed [satoi_pkg::PLO_W-1:0] r_plo [NF];
    logic signed [satoi_pkg::PHI_W-1:0] r_phi [NF];
    logic signed [satoi_pkg::SH_W-1:0]  r_sh  [NF];
    logic signed [QW-1:0]               r_q1 [NF], r_q2 [NF], r_q3 [NF];
    logic signed [GW-1:0]               r_hi1 [NF], r_lo1 [NF], r_hi2 [NF], r_lo2 [NF];
    logic [NF-1:0]                      r_ok1, r_ok2, r_ok3, r_cand;

    // Stage 1: t * d as two partial products
    always_ff @(posedge i_clk) begin
        logic signed [satoi_pkg::D_W-1:0] d;
        if (i_en[0]) begin
            for (int k = 0; k < NF; k++) begin
                d = (k < 2) ? i_geom.d_y : i_geom.d_x;
                r_plo[k] <= $signed({{(satoi_pkg::PLO_W-QW){i_q[k][QW-1]}}, i_q[k]})
                          * $signed({{(satoi_pkg::PLO_W-satoi_pkg::DLO_W){1'b0}},
                                     d[satoi_pkg::DLO_W-1:0]});
                r_phi[k] <= $signed({{(satoi_pkg::PHI_W-QW){i_q[k][QW-1]}}, i_q[k]})
                          * $signed({{(satoi_pkg::PHI_W-DHW){d[satoi_pkg::D_W-1]}},
                                     d[satoi_pkg::D_W-1:satoi_pkg::DLO_W]});
                r_q1[k]  <= i_q[k];
                // upper and lower bound of the other-axis overlap window
                r_hi1[k] <= (k < 2) ? i_geom.gap_t : i_geom.gap_r;
                r_lo1[k] <= (k < 2) ? i_geom.gap_b : i_geom.gap_l;
            end
            r_ok1 <= {i_geom.ok_y, i_geom.ok_y, i_geom.ok_x, i_geom.ok_x};
        end
    end

    // Stage 2: shift = t * d
    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            for (int k = 0; k < NF; k++) begin
                r_sh[k] <= $signed({{(satoi_pkg::SH_W-satoi_pkg::PHI_W-satoi_pkg::DLO_W)
                                     {r_phi[k][satoi_pkg::PHI_W-1]}},
                                    r_phi[k], {satoi_pkg::DLO_W{1'b0}}})
                         + $signed({{(satoi_pkg::SH_W-satoi_pkg::PLO_W)
                                     {r_plo[k][satoi_pkg::PLO_W-1]}}, r_plo[k]});
                r_q2[k]  <= r_q1[k];
                r_hi2[k] <= r_hi1[k];
                r_lo2[k] <= r_lo1[k];
            end
            r_ok2 <= r_ok1;
        end
    end

    // Stage 3: open-interval overlap compare
    always_ff @(posedge i_clk) begin
        logic signed [satoi_pkg::SH_W-1:0] hi, lo;
        if (i_en[2]) begin
            for (int k = 0; k < NF; k++) begin
                hi = $signed({{(satoi_pkg::SH_W-GW-satoi_pkg::FRAC_SH){r_hi2[k][GW-1]}},
                              r_hi2[k], {satoi_pkg::FRAC_SH{1'b0}}});
                lo = $signed({{(satoi_pkg::SH_W-GW-satoi_pkg::FRAC_SH){r_lo2[k][GW-1]}},
                              r_lo2[k], {satoi_pkg::FRAC_SH{1'b0}}});
                r_cand[k] <= r_ok2[k] && (r_sh[k] < hi) && (r_sh[k] > lo);
                r_q3[k]   <= r_q2[k];
            end
            r_ok3 <= r_ok2;
        end
    end

    assign o_q    = r_q3;
    assign o_ok   = r_ok3;
    assign o_cand = r_cand;
endmodule
`default_nettype wire

>>> src/swept_aabb_time_of_impact.sv
// Top level: swept box time-of-impact pipeline
//
// Tests box A, moving by rel_vel * time_span, against box B and reports the
// earliest face impact fraction (Q1.16), a hit status and four normal flags.
// Input channel i_in (sink) takes one box pair per transaction; output channel
// o_out (source) gives exactly one result per pair, in order.
// Latency: 15 register stages from i_in to o_out: two setup stages, eight
// stages of a radix-2 restoring divider retiring three quotient bits each plus
// a fixup stage, three overlap stages (split multiply, sum, compare) and the
// min/flag output register.
// Throughput: one pair per cycle unless o_out stalls; the staged divider sets depth.
// Every stage has its own valid bit and advances when the stage after it is
// empty or moving, so bubbles close up and input is taken while a result
// waits. A stalled o_out holds its payload; input stalls only once every
// stage holds a pair. No transaction is dropped or repeated.
// Reset (i_rst_n low, synchronous) clears all valid bits; data registers are
// not reset. There is no configuration and no state between pairs.
`default_nettype none
module swept_aabb_time_of_impact (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    satoi_stream_if.sink      i_in,
    satoi_stream_if.source    o_out
);
    localparam int NS = satoi_pkg::NSTG;
    localparam int NF = satoi_pkg::NFACE;
    localparam int DS = satoi_pkg::DIV_STAGES;
    localparam int GD = satoi_pkg::GEOM_DLY;
    localparam int OV = 2 + GD;                  // first overlap stage

    logic [NS-1:0]                      r_vld;
    logic [NS:0]                        w_en;
    satoi_pkg::t_geom                   w_geom;
    satoi_pkg::t_geom                   r_geom [GD];
    satoi_pkg::t_div_in                 w_div [NF];
    logic signed [satoi_pkg::Q_W-1:0]   w_q [NF];
    logic signed [satoi_pkg::Q_W-1:0]   w_q_ov [NF];
    logic [NF-1:0]                      w_ok, w_cand;
    satoi_pkg::t_out_item               r_out, n_out;

    // Stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[NS] = o_out.ready;
        for (int k = NS - 1; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_in.valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign i_in.ready = w_en[0];

    satoi_prep u_prep (
        .i_clk  (i_clk),
        .i_en   (w_en[1:0]),
        .i_item (i_in.payload),
        .o_geom (w_geom),
        .o_div  (w_div)
    );

    for (genvar f = 0; f < NF; f++) begin : g_face
        satoi_div u_div (
            .i_clk (i_clk),
            .i_en  (w_en[2+DS:2]),
            .i_div (w_div[f]),
            .o_q   (w_q[f])
        );
    end

    // Geometry delay matching the divider depth
    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_geom[0] <= w_geom;
        end
        for (int j = 1; j < GD; j++) begin
            if (w_en[2+j]) begin
                r_geom[j] <= r_geom[j-1];
            end
        end
    end

    satoi_ovl u_ovl (
        .i_clk  (i_clk),
        .i_en   (w_en[OV+2:OV]),
        .i_q    (w_q),
        .i_geom (r_geom[GD-1]),
        .o_q    (w_q_ov),
        .o_ok   (w_ok),
        .o_cand (w_cand)
    );

    // Output stage: minimum over candidates, status and normal flags
    always_comb begin
        logic signed [satoi_pkg::Q_W-1:0] v [NF];
        logic signed [satoi_pkg::Q_W-1:0] m01, m23, mn;
        logic                             hit;
        for (int k = 0; k < NF; k++) begin
            v[k] = w_cand[k] ? w_q_ov[k] : satoi_pkg::Q_START;
        end
        m01 = (v[satoi_pkg::FACE_L] < v[satoi_pkg::FACE_R]) ? v[satoi_pkg::FACE_L]
                                                            : v[satoi_pkg::FACE_R];
        m23 = (v[satoi_pkg::FACE_B] < v[satoi_pkg::FACE_T]) ? v[satoi_pkg::FACE_B]
                                                            : v[satoi_pkg::FACE_T];
        mn  = (m23 < m01) ? m23 : m01;
        hit = (mn >= satoi_pkg::Q_ZERO) && (mn <= satoi_pkg::Q_ONE);

        if (!hit) begin
            n_out.hit_status = satoi_pkg::HIT_NONE;
        end else if (mn == satoi_pkg::Q_ZERO) begin
            n_out.hit_status = satoi_pkg::HIT_TOUCH;
        end else begin
            n_out.hit_status = satoi_pkg::HIT_SPAN;
        end
        n_out.impact_fraction = hit ? mn[satoi_pkg::FRAC_OUT_W-1:0] : '0;
        n_out.normal_right = hit && w_ok[satoi_pkg::FACE_R] && (w_q_ov[satoi_pkg::FACE_R] == mn);
        n_out.normal_left  = hit && w_ok[satoi_pkg::FACE_L] && (w_q_ov[satoi_pkg::FACE_L] == mn);
        n_out.normal_up    = hit && w_ok[satoi_pkg::FACE_T] && (w_q_ov[satoi_pkg::FACE_T] == mn);
        n_out.normal_down  = hit && w_ok[satoi_pkg::FACE_B] && (w_q_ov[satoi_pkg::FACE_B] == mn);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[NS-1]) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid   = r_vld[NS-1];
    assign o_out.payload = r_out;

    // No hit carries a zero fraction and no normals
    a_nohit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.payload.hit_status == satoi_pkg::HIT_NONE) |->
        (o_out.payload.impact_fraction == '0) && !o_out.payload.normal_up &&
        !o_out.payload.normal_down && !o_out.payload.normal_left &&
        !o_out.payload.normal_right)
        else $error("no-hit result with nonzero fraction or normal");

    // A hit always names at least one face
    a_hit_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.payload.hit_status != satoi_pkg::HIT_NONE) |->
        (o_out.payload.normal_up || o_out.payload.normal_down ||
         o_out.payload.normal_left || o_out.payload.normal_right))
        else $error("hit without a normal flag");

    // Touching means fraction zero
    a_touch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && (o_out.payload.hit_status == satoi_pkg::HIT_TOUCH) |->
        (o_out.payload.impact_fraction == '0))
        else $error("touch status with nonzero fraction");

    // An accepted transaction occupies the first stage
    a_accept_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transaction lost at first stage");
endmodule
`default_nettype wire
